### hdl/bmq_pkg.sv
// Package: opcodes and constants for the bf16 MX quantize ALU.
`timescale 1ns / 1ps
`default_nettype none
package bmq_pkg;
    typedef enum logic [2:0] {
        OP_INT8PACK  = 3'd0,
        OP_UNPACK_HI = 3'd1,
        OP_UNPACK_LO = 3'd2,
        OP_PACK      = 3'd3,
        OP_ABSMAX    = 3'd4,
        OP_SHAREDEXP = 3'd5,
        OP_QUANT     = 3'd6,
        OP_NONE      = 3'd7
    } op_t;
    localparam logic [15:0] ABS_MASK = 16'h7FFF;
    localparam logic [15:0] INF_BITS = 16'h7F80;
    localparam logic [7:0]  EXP_BIAS = 8'd127;
    localparam logic [7:0]  EXP_OFS  = 8'd6;
    localparam logic [15:0] SAT_POS  = 16'h007F;
    localparam logic [15:0] SAT_NEG  = 16'hFF80;
endpackage
`default_nettype wire

### hdl/bf16_mx_quantize_alu_core.sv
// Top level: three-stage pipelined bf16 MX quantize ALU.
//  channel | signals                                  | direction
//  in      | in_valid in_stall op operand_a operand_b | to block
//  out     | out_valid out_stall result               | from block
// One transfer per cycle unless out_stall holds a valid result; stages are decode, shift, select/saturate.
// The stage chain advances whenever the output stage is empty or its result is taken.
// Reset clears the valid bits only. A stall holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none
module bf16_mx_quantize_alu_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  op,
    input  wire logic [15:0] operand_a,
    input  wire logic [15:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      result
);
    logic v1_reg, v2_reg, v3_reg;
    logic adv;
    assign adv = !(v3_reg && out_stall);
    assign in_stall = !adv;

    // stage 1: decode
    logic [2:0]  op1_reg;
    logic [15:0] a1_reg, b1_reg;
    logic        a_ok1_reg, b_ok1_reg;   // int8pack exponent in range
    logic [3:0]  ua1_reg, ub1_reg;
    logic        amax1_reg;
    logic        qnan1_reg, qsat1_reg, qzero1_reg, qleft1_reg;
    logic [3:0]  qsh1_reg;
    logic [7:0]  qsig1_reg;

    logic [7:0]  ea, eb, qsig;
    logic [18:0] s_full;   // signed shift, e - 7 - b
    logic        qnan, qsat, qzero, qleft;
    logic [3:0]  qsh;
    logic [15:0] aa, ab;
    always_comb
    begin
        ea = operand_a[14:7];
        eb = operand_b[14:7];
        aa = operand_a & bmq_pkg::ABS_MASK;
        ab = operand_b & bmq_pkg::ABS_MASK;
        qsig = (ea == 8'd0) ? {1'b0, operand_a[6:0]} : {1'b1, operand_a[6:0]};
        s_full = {11'd0, ((ea == 8'd0) ? 8'd1 : ea)} - 19'd7 - {3'd0, operand_b};
        qnan = 1'b0; qsat = 1'b0; qzero = 1'b0; qleft = 1'b0; qsh = 4'd0;
        if (ea == 8'hFF)
        begin
            if (operand_a[6:0] != 7'd0) qnan = 1'b1;
            else qsat = 1'b1;
        end
        else if (qsig == 8'd0) qzero = 1'b1;
        else if (!s_full[18] && s_full >= 19'd8) qsat = 1'b1;
        else if (!s_full[18])
        begin
            qleft = 1'b1;
            qsh = s_full[3:0];
        end
        else if (s_full <= 19'h7FFF7) qzero = 1'b1;   // t >= 9
        else qsh = 4'(-s_full[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg   <= op;
            a1_reg    <= operand_a;
            b1_reg    <= operand_b;
            a_ok1_reg <= (ea >= bmq_pkg::EXP_BIAS) && (ea - bmq_pkg::EXP_BIAS < 8'd15);
            b_ok1_reg <= (eb >= bmq_pkg::EXP_BIAS) && (eb - bmq_pkg::EXP_BIAS < 8'd15);
            ua1_reg   <= 4'(ea - bmq_pkg::EXP_BIAS);
            ub1_reg   <= 4'(eb - bmq_pkg::EXP_BIAS);
            amax1_reg <= !(aa > bmq_pkg::INF_BITS) && !(ab > bmq_pkg::INF_BITS) && (aa > ab);
            qnan1_reg <= qnan; qsat1_reg <= qsat; qzero1_reg <= qzero;
            qleft1_reg <= qleft; qsh1_reg <= qsh; qsig1_reg <= qsig;
        end
    end

    // stage 2: shifts
    logic [2:0]  op2_reg;
    logic [15:0] a2_reg, b2_reg;
    logic        amax2_reg, qnan2_reg, qsat2_reg;
    logic [7:0]  ma2_reg, mb2_reg;
    logic [15:0] q2_reg;
    logic [22:0] shl_a, shl_b;
    logic [15:0] qv;
    always_comb
    begin
        shl_a = {15'd0, 1'b1, a1_reg[6:0]} << ua1_reg;
        shl_b = {15'd0, 1'b1, b1_reg[6:0]} << ub1_reg;
        if (qzero1_reg) qv = 16'd0;
        else if (qleft1_reg) qv = {8'd0, qsig1_reg} << qsh1_reg[2:0];
        else qv = ({8'd0, qsig1_reg} + (16'd1 << (qsh1_reg - 4'd1))) >> qsh1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg <= op1_reg; a2_reg <= a1_reg; b2_reg <= b1_reg;
            amax2_reg <= amax1_reg; qnan2_reg <= qnan1_reg; qsat2_reg <= qsat1_reg;
            ma2_reg <= a_ok1_reg ? shl_a[14:7] : 8'd0;
            mb2_reg <= b_ok1_reg ? shl_b[14:7] : 8'd0;
            q2_reg <= qv;
        end
    end

    // stage 3: select
    logic [15:0] r;
    logic [7:0]  ba, bb, e2;
    always_comb
    begin
        ba = a2_reg[15] ? 8'(-ma2_reg) : ma2_reg;
        bb = b2_reg[15] ? 8'(-mb2_reg) : mb2_reg;
        e2 = a2_reg[14:7];
        case (bmq_pkg::op_t'(op2_reg))
            bmq_pkg::OP_INT8PACK:  r = {ba, bb};
            bmq_pkg::OP_UNPACK_HI: r = {8'd0, a2_reg[15:8]};
            bmq_pkg::OP_UNPACK_LO: r = {8'd0, a2_reg[7:0]};
            bmq_pkg::OP_PACK:      r = {a2_reg[7:0], b2_reg[7:0]};
            bmq_pkg::OP_ABSMAX:
                r = amax2_reg ? (a2_reg & bmq_pkg::ABS_MASK) : (b2_reg & bmq_pkg::ABS_MASK);
            bmq_pkg::OP_SHAREDEXP:
                r = (e2 == 8'd0) ? {8'd0, bmq_pkg::EXP_BIAS}
                                 : {8'd0, e2} - {8'd0, bmq_pkg::EXP_OFS};
            bmq_pkg::OP_QUANT:
                if (qnan2_reg) r = 16'd0;
                else if (a2_reg[15])
                    r = (qsat2_reg || q2_reg > 16'd128) ? bmq_pkg::SAT_NEG : 16'(-q2_reg);
                else
                    r = (qsat2_reg || q2_reg > 16'd127) ? bmq_pkg::SAT_POS : q2_reg;
            default: r = 16'd0;
        endcase
    end
    always_ff @(posedge clk)
    begin
        if (adv) result <= r;
    end
    assign out_valid = v3_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("result changed under stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |=> out_valid == $past(v2_reg))
        else $error("pipeline lost an item");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");
endmodule
`default_nettype wire

### tb/bf16_mx_quantize_alu_core_test.sv
// Testbench: bf16 MX quantize ALU, randomized and directed transfers checked against a predictor.
`timescale 1ns / 1ps
module bf16_mx_quantize_alu_core_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = bmq_pkg::OP_NONE;
    logic [15:0] operand_a = '0;
    logic [15:0] operand_b = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result;

    logic [15:0] expected_q[$];
    int          mismatches = 0;
    int          sent = 0;
    int          checked = 0;
    bit          rx_idle_off = 1'b0;

    bf16_mx_quantize_alu_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall), .result(result)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] to_int8(logic [15:0] x);
        logic [7:0]  ex;
        logic [22:0] sh;
        logic [7:0]  mag;
        ex = x[14:7];
        if (ex < bmq_pkg::EXP_BIAS || ex - bmq_pkg::EXP_BIAS >= 15)
            return 8'd0;
        sh = {15'd0, 1'b1, x[6:0]} << (ex - bmq_pkg::EXP_BIAS);
        mag = sh[14:7];
        return x[15] ? 8'(-mag) : mag;
    endfunction

    function automatic logic [15:0] quantize(logic [15:0] a, logic [15:0] b);
        logic [7:0] ex;
        logic [8:0] sig;
        int         s;
        int         t;
        int         q;
        bit         sat;
        ex = a[14:7];
        sat = 1'b0;
        q = 0;
        if (ex == 8'hFF) begin
            if (a[6:0] != 0)
                return 16'd0;
            sat = 1'b1;
        end else begin
            if (ex == 0) begin
                if (a[6:0] == 0)
                    return 16'd0;
                sig = {2'b0, a[6:0]};
                s = -6 - int'(b);
            end else begin
                sig = {2'b1, a[6:0]};
                s = int'(ex) - 7 - int'(b);
            end
            if (s >= 8)
                sat = 1'b1;
            else if (s >= 0)
                q = int'(sig) << s;
            else begin
                t = -s;
                q = (t >= 9) ? 0 : ((int'(sig) + (1 << (t - 1))) >> t);
            end
        end
        if (a[15]) begin
            if (sat || q > 128)
                q = 128;
            return 16'(-q);
        end
        if (sat || q > 127)
            q = 127;
        return 16'(q);
    endfunction

    function automatic logic [15:0] alu_predict(bmq_pkg::op_t code, logic [15:0] a,
                                                logic [15:0] b);
        logic [15:0] ma;
        logic [15:0] mb;
        ma = a & bmq_pkg::ABS_MASK;
        mb = b & bmq_pkg::ABS_MASK;
        case (code)
            bmq_pkg::OP_INT8PACK:  return {to_int8(a), to_int8(b)};
            bmq_pkg::OP_UNPACK_HI: return {8'd0, a[15:8]};
            bmq_pkg::OP_UNPACK_LO: return {8'd0, a[7:0]};
            bmq_pkg::OP_PACK:      return {a[7:0], b[7:0]};
            bmq_pkg::OP_ABSMAX:
                return (ma <= bmq_pkg::INF_BITS && mb <= bmq_pkg::INF_BITS && ma > mb) ? ma : mb;
            bmq_pkg::OP_SHAREDEXP:
                return (a[14:7] == 0) ? 16'd127 : 16'(a[14:7]) - 16'(bmq_pkg::EXP_OFS);
            bmq_pkg::OP_QUANT:     return quantize(a, b);
            default:               return 16'd0;
        endcase
    endfunction

    task automatic send_op(bmq_pkg::op_t code, logic [15:0] a, logic [15:0] b, bit gap);
        int wait_n;
        wait_n = gap ? $urandom_range(0, 16) : 0;
        repeat (wait_n) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(alu_predict(code, a, b));
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: result=%h", result);
            end else begin
                logic [15:0] want;
                want = expected_q.pop_front();
                checked++;
                if (result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, result);
                end
            end
        end
    end

    initial begin
        int hold;
        @(negedge clk);
        forever begin
            hold = rx_idle_off ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0)
                hold = 0;
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(negedge clk);
        end
    end

    task automatic test_int8pack();
        send_op(bmq_pkg::OP_INT8PACK, 16'h3F80, 16'hBF80, 1'b0);
        send_op(bmq_pkg::OP_INT8PACK, 16'h42FE, 16'hC300, 1'b0);
        send_op(bmq_pkg::OP_INT8PACK, 16'h3F00, 16'h0001, 1'b0);
        send_op(bmq_pkg::OP_INT8PACK, 16'h4700, 16'h46FF, 1'b0);
        send_op(bmq_pkg::OP_INT8PACK, 16'h7F80, 16'hFFC1, 1'b0);
    endtask

    task automatic test_bytes();
        send_op(bmq_pkg::OP_UNPACK_HI, 16'hFFFF, 16'h0000, 1'b0);
        send_op(bmq_pkg::OP_UNPACK_LO, 16'hA55A, 16'hFFFF, 1'b0);
        send_op(bmq_pkg::OP_PACK, 16'h12FF, 16'hEE00, 1'b0);
        send_op(bmq_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_absmax();
        send_op(bmq_pkg::OP_ABSMAX, 16'hC000, 16'h3F80, 1'b0);
        send_op(bmq_pkg::OP_ABSMAX, 16'hC000, 16'h4000, 1'b0);
        send_op(bmq_pkg::OP_ABSMAX, 16'h7FC0, 16'h3F80, 1'b0);
        send_op(bmq_pkg::OP_ABSMAX, 16'h3F80, 16'hFFC1, 1'b0);
        send_op(bmq_pkg::OP_ABSMAX, 16'hFF80, 16'h0000, 1'b0);
    endtask

    task automatic test_sharedexp();
        send_op(bmq_pkg::OP_SHAREDEXP, 16'h0000, 16'h0, 1'b0);
        send_op(bmq_pkg::OP_SHAREDEXP, 16'h0080, 16'h0, 1'b0);
        send_op(bmq_pkg::OP_SHAREDEXP, 16'h02FF, 16'h0, 1'b0);
        send_op(bmq_pkg::OP_SHAREDEXP, 16'hFFFF, 16'h0, 1'b0);
    endtask

    task automatic test_quant();
        send_op(bmq_pkg::OP_QUANT, 16'h7FC1, 16'd127, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'h7F80, 16'd127, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'hFF80, 16'd127, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'h8000, 16'd0, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'h0040, 16'd0, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'h3FC0, 16'd127, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'hBFC0, 16'd127, 1'b0);
        send_op(bmq_pkg::OP_QUANT, 16'h4000, 16'hFFFF, 1'b0);
    endtask

    task automatic test_random(int count);
        bmq_pkg::op_t code;
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < count; i++) begin
            code = bmq_pkg::op_t'($urandom_range(0, 7));
            a = 16'($urandom);
            b = 16'($urandom);
            if ($urandom_range(0, 1)) begin
                a[14:7] = 8'($urandom_range(110, 145));
                if (code == bmq_pkg::OP_QUANT)
                    b = 16'($urandom_range(110, 145));
            end
            if (i == count / 2) begin
                drain_results();
                rx_idle_off = ~rx_idle_off;
            end
            send_op(code, a, b, (i % 100) < 70);
        end
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_int8pack();
        test_bytes();
        test_absmax();
        test_sharedexp();
        test_quant();
        drain_results();
        test_random(700);
        drain_results();
        repeat (10) @(posedge clk);
        $display("covered %0d transfers over all opcodes, %0d results compared", sent, checked);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("bf16_mx_quantize_alu_core_test: clean");
        else
            $display("bf16_mx_quantize_alu_core_test: errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("bf16_mx_quantize_alu_core_test: errors");
        $finish;
    end
endmodule
